// ----- design/lsuk_pkg.sv -----
// types and codes shared by the unique-key lifo stack
// no dependencies
package lsuk_pkg;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned KEY_W       = 32;
	localparam int unsigned VAL_W       = 32;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic signed [31:0] in_key;
		logic signed [31:0] in_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_key;
		logic signed [31:0] out_value;
		logic               is_empty;
		logic [4:0]         entry_count;
	} rsp_t;

	// per-cell control from the stack controller
	typedef struct packed {
		logic push;
		logic pop;
		logic in_use;
	} cell_ctl_t;

endpackage

// ----- design/lsuk_cell.sv -----
// one stack cell: holds a key/value entry, shifts with its neighbours
// depends on lsuk_pkg
module lsuk_cell (
	input  logic                          clk,
	input  lsuk_pkg::cell_ctl_t           ctl,
	input  logic [lsuk_pkg::KEY_W-1:0]    probe_key,
	input  logic [lsuk_pkg::KEY_W-1:0]    above_key,
	input  logic [lsuk_pkg::VAL_W-1:0]    above_val,
	input  logic [lsuk_pkg::KEY_W-1:0]    below_key,
	input  logic [lsuk_pkg::VAL_W-1:0]    below_val,
	output logic [lsuk_pkg::KEY_W-1:0]    key_q,
	output logic [lsuk_pkg::VAL_W-1:0]    val_q,
	output logic                          match
);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			key_q <= above_key;
			val_q <= above_val;
		end else if (ctl.pop) begin
			key_q <= below_key;
			val_q <= below_val;
		end
	end

	assign match = ctl.in_use && (key_q == probe_key);

endmodule

// ----- design/lifo_stack_unique_keys.sv -----
// top level of the unique-key lifo stack: controller, cell chain, result register
// depends on lsuk_pkg and lsuk_cell
//
// A last-in-first-out stack of key/value entries kept in a chain of cells, cell 0
// holding the top entry. A push shifts every entry one cell down and writes the new
// entry into cell 0; a pop shifts every entry one cell up. Each cell compares its own
// key against the incoming key at the same time, so the duplicate check covers every
// cell at once however deep the stack is. Every operation gives exactly one result in
// the result register, in the cycle after the request transfer. A new
// request is taken every cycle as long as the result side takes its transfers; while
// a result is held up by rsp_stall, req_stall is raised. The path that sets the clock
// is the key compare in every cell, the or of all matches and the shift enable back
// into the chain. A duplicate key is refused before a full stack, pop and peek on an
// empty stack report empty, and an unused opcode returns ok with the current count.
// entry_count shows the count modulo 32.
module lifo_stack_unique_keys #(
	parameter int unsigned StackDepth = lsuk_pkg::STACK_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lsuk_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output lsuk_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);

	localparam int unsigned CountW = $clog2(StackDepth + 1);

	// fill level and result register
	logic [CountW-1:0] fill_q;
	logic              rsp_valid_q;
	lsuk_pkg::rsp_t    rsp_q;

	// chain wiring
	logic [lsuk_pkg::KEY_W-1:0] cell_key [StackDepth];
	logic [lsuk_pkg::VAL_W-1:0] cell_val [StackDepth];
	logic [StackDepth-1:0]      cell_match;
	lsuk_pkg::cell_ctl_t        cell_ctl [StackDepth];

	logic              accept;
	logic              is_push;
	logic              is_pop;
	logic              is_peek;
	logic              dup;
	logic              full;
	logic              empty;
	logic              push_ok;
	logic              pop_ok;
	logic [CountW-1:0] fill_next;
	logic [CountW+4:0] count_ext;
	lsuk_pkg::rsp_t    rsp_next;

	// hold requests only while a finished result waits
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign is_push = (req.opcode == lsuk_pkg::OP_PUSH);
	assign is_pop  = (req.opcode == lsuk_pkg::OP_POP);
	assign is_peek = (req.opcode == lsuk_pkg::OP_PEEK);

	assign dup     = |cell_match;
	assign full    = (fill_q == CountW'(StackDepth));
	assign empty   = (fill_q == '0);
	assign push_ok = accept && is_push && !dup && !full;
	assign pop_ok  = accept && is_pop && !empty;

	// chain of cells, cell 0 is the top of the stack
	for (genvar i = 0; i < StackDepth; i++) begin : g_cell
		logic [lsuk_pkg::KEY_W-1:0] up_key;
		logic [lsuk_pkg::VAL_W-1:0] up_val;
		logic [lsuk_pkg::KEY_W-1:0] dn_key;
		logic [lsuk_pkg::VAL_W-1:0] dn_val;

		if (i == 0) begin : g_top
			assign up_key = req.in_key;
			assign up_val = req.in_value;
		end else begin : g_mid
			assign up_key = cell_key[i-1];
			assign up_val = cell_val[i-1];
		end

		if (i == StackDepth - 1) begin : g_bottom
			// nothing below the last cell, the vacated entry is never read
			assign dn_key = cell_key[i];
			assign dn_val = cell_val[i];
		end else begin : g_inner
			assign dn_key = cell_key[i+1];
			assign dn_val = cell_val[i+1];
		end

		assign cell_ctl[i].push   = push_ok;
		assign cell_ctl[i].pop    = pop_ok;
		assign cell_ctl[i].in_use = (CountW'(i) < fill_q);

		lsuk_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.probe_key (req.in_key),
			.above_key (up_key),
			.above_val (up_val),
			.below_key (dn_key),
			.below_val (dn_val),
			.key_q     (cell_key[i]),
			.val_q     (cell_val[i]),
			.match     (cell_match[i])
		);
	end

	// fill level after this operation
	always_comb begin
		fill_next = fill_q;
		if (push_ok) begin
			fill_next = fill_q + CountW'(1);
		end else if (pop_ok) begin
			fill_next = fill_q - CountW'(1);
		end
	end

	// count shown modulo 32
	assign count_ext = {5'b0, fill_next};

	always_comb begin
		rsp_next             = '0;
		rsp_next.status      = lsuk_pkg::ST_OK;
		rsp_next.is_empty    = (fill_next == '0);
		rsp_next.entry_count = count_ext[4:0];
		if (is_push) begin
			if (dup) begin
				rsp_next.status = lsuk_pkg::ST_DUP;
			end else if (full) begin
				rsp_next.status = lsuk_pkg::ST_FULL;
			end
		end else if (is_pop || is_peek) begin
			if (empty) begin
				rsp_next.status = lsuk_pkg::ST_EMPTY;
			end else begin
				rsp_next.out_key   = cell_key[0];
				rsp_next.out_value = cell_val[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on every request transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef ASSERT_OFF
	// fill level stays within the chain
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CountW'(StackDepth))
		else $error("fill level beyond stack depth");

	// a taken result with no new request leaves the result register empty
	a_rsp_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && !(req_valid && !req_stall)) |=> !rsp_valid)
		else $error("result shown twice");

	// a pop on a non-empty stack lowers the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.opcode == lsuk_pkg::OP_POP && fill_q != '0)
		|=> fill_q == $past(fill_q) - CountW'(1))
		else $error("pop did not lower the count");

	// the shown empty flag matches the stored fill level
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (fill_q == '0)))
		else $error("empty flag out of step with fill level");
`endif

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the unique-key lifo stack: directed and random push, pop and peek
// depends on lsuk_pkg and lifo_stack_unique_keys; carries its own stack predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// opcode 3 has no meaning in the block but must still give one result
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CycleLimit  = 200000;
	localparam int         ReportLimit = 10;
	localparam int         RandomItems = 625;

	logic clk;
	logic arst_n;
	lsuk_pkg::req_t req;
	logic req_valid;
	logic req_stall;
	lsuk_pkg::rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall;

	// requests still to be offered, and results the stack owes us in order
	lsuk_pkg::req_t req_feed[$];
	lsuk_pkg::rsp_t results_due[$];

	// shadow copy of the stack contents, index 0 at the bottom
	logic signed [31:0] held_key[lsuk_pkg::STACK_DEPTH];
	logic signed [31:0] held_val[lsuk_pkg::STACK_DEPTH];
	int                 held;

	logic req_taken;
	int   cycle_count;
	int   fault_count;

	lifo_stack_unique_keys i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// apply one request to the shadow stack and return the result it should give
	function automatic lsuk_pkg::rsp_t stack_apply(lsuk_pkg::req_t r);
		lsuk_pkg::rsp_t res;
		logic hit;
		res = '0;
		hit = 1'b0;
		case (r.opcode)
			lsuk_pkg::OP_PUSH: begin
				// the duplicate check wins over the full check
				for (int i = 0; i < held; i++)
					if (held_key[i] == r.in_key)
						hit = 1'b1;
				if (hit) begin
					res.status = lsuk_pkg::ST_DUP;
				end else if (held >= lsuk_pkg::STACK_DEPTH) begin
					res.status = lsuk_pkg::ST_FULL;
				end else begin
					held_key[held] = r.in_key;
					held_val[held] = r.in_value;
					held++;
				end
			end
			lsuk_pkg::OP_POP, lsuk_pkg::OP_PEEK: begin
				if (held == 0) begin
					res.status = lsuk_pkg::ST_EMPTY;
				end else begin
					res.out_key   = held_key[held - 1];
					res.out_value = held_val[held - 1];
					if (r.opcode == lsuk_pkg::OP_POP)
						held--;
				end
			end
			default: ;
		endcase
		res.is_empty    = (held == 0);
		res.entry_count = held[4:0];
		return res;
	endfunction

	function automatic lsuk_pkg::req_t make_req(logic [1:0] op, logic signed [31:0] k,
		logic signed [31:0] v);
		lsuk_pkg::req_t r;
		r.opcode   = op;
		r.in_key   = k;
		r.in_value = v;
		return r;
	endfunction

	// no idling on either side for a stretch in the middle of the run
	function automatic logic idle_allowed();
		return !(cycle_count >= 300 && cycle_count < 500);
	endfunction

	// driver: a new request goes out at the falling edge once the last one has transferred
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (req_feed.size() > 0 && !(idle_allowed() && $urandom_range(99) < 10)) begin
					req       <= req_feed.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= idle_allowed() && ($urandom_range(99) < 10);
		end
	end

	// monitor: every request transfer feeds the predictor, every result transfer is checked
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall)
				results_due.push_back(stack_apply(req));
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					fault_count++;
					if (fault_count <= ReportLimit)
						$display("result with nothing outstanding: status %0d key %0d val %0d",
							rsp.status, rsp.out_key, rsp.out_value);
				end else begin
					lsuk_pkg::rsp_t want;
					want = results_due.pop_front();
					if (rsp.status !== want.status || rsp.out_key !== want.out_key ||
						rsp.out_value !== want.out_value || rsp.is_empty !== want.is_empty ||
						rsp.entry_count !== want.entry_count) begin
						fault_count++;
						if (fault_count <= ReportLimit)
							$display(
								"mismatch: exp %0d/%0d/%0d/%0b/%0d got %0d/%0d/%0d/%0b/%0d",
								want.status, want.out_key, want.out_value, want.is_empty,
								want.entry_count, rsp.status, rsp.out_key, rsp.out_value,
								rsp.is_empty, rsp.entry_count);
					end
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] key_pool[24];
		int                 mode;
		int                 burst;
		int                 pick;
		int                 made;
		logic [1:0]         op;
		logic signed [31:0] k;

		arst_n      = 1'b0;
		req         = '0;
		req_valid   = 1'b0;
		rsp_stall   = 1'b0;
		req_taken   = 1'b0;
		held        = 0;
		cycle_count = 0;
		fault_count = 0;

		// directed: empty stack, extreme keys and values, duplicates, then fill to full
		req_feed.push_back(make_req(lsuk_pkg::OP_PEEK, 32'sd5, 32'sd6));
		req_feed.push_back(make_req(lsuk_pkg::OP_POP, -32'sd1, -32'sd1));
		req_feed.push_back(make_req(OP_UNUSED, 32'sh7fffffff, 32'sh80000000));
		req_feed.push_back(make_req(lsuk_pkg::OP_PUSH, 32'sh80000000, 32'sh7fffffff));
		req_feed.push_back(make_req(lsuk_pkg::OP_PUSH, 32'sh7fffffff, 32'sh80000000));
		req_feed.push_back(make_req(lsuk_pkg::OP_PUSH, 32'sh80000000, 32'sd0));
		req_feed.push_back(make_req(lsuk_pkg::OP_PEEK, 32'sd0, 32'sd0));
		for (int j = 0; j < lsuk_pkg::STACK_DEPTH - 2; j++) begin
			k = (j == 0) ? 32'sd0 : (j == 1) ? -32'sd1 : 32'sh00001000 + j;
			req_feed.push_back(make_req(lsuk_pkg::OP_PUSH, k, $urandom));
		end
		// a fresh key on a full stack is refused as full, a stored one as duplicate
		req_feed.push_back(make_req(lsuk_pkg::OP_PUSH, 32'sh12345678, 32'sd1));
		req_feed.push_back(make_req(lsuk_pkg::OP_PUSH, -32'sd1, 32'sd2));
		req_feed.push_back(make_req(OP_UNUSED, 32'sd0, 32'sd0));
		req_feed.push_back(make_req(lsuk_pkg::OP_POP, 32'sd0, 32'sd0));

		// keys drawn mostly from a small pool so that duplicates turn up often
		key_pool[0] = 32'sh80000000;
		key_pool[1] = 32'sh7fffffff;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int j = 4; j < 24; j++)
			key_pool[j] = $urandom;

		// random: bursts that fill, drain or mix, so full and empty are both reached often
		made = 0;
		while (made < RandomItems) begin
			mode  = $urandom_range(2);
			burst = $urandom_range(40, 10);
			for (int j = 0; j < burst && made < RandomItems; j++) begin
				pick = $urandom_range(99);
				case (mode)
					0: op = (pick < 80) ? lsuk_pkg::OP_PUSH : (pick < 90) ? lsuk_pkg::OP_POP :
						(pick < 97) ? lsuk_pkg::OP_PEEK : OP_UNUSED;
					1: op = (pick < 15) ? lsuk_pkg::OP_PUSH : (pick < 80) ? lsuk_pkg::OP_POP :
						(pick < 95) ? lsuk_pkg::OP_PEEK : OP_UNUSED;
					default: op = (pick < 45) ? lsuk_pkg::OP_PUSH :
						(pick < 78) ? lsuk_pkg::OP_POP :
						(pick < 96) ? lsuk_pkg::OP_PEEK : OP_UNUSED;
				endcase
				k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(23)] : $urandom;
				req_feed.push_back(make_req(op, k, $urandom));
				made++;
			end
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// wait for every request to transfer and every result to come back
		while (req_feed.size() != 0 || req_valid || results_due.size() != 0)
			@(posedge clk);
		// a final pause catches any stray result
		repeat (10) @(posedge clk);
		if (fault_count == 0 && results_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lsuk_pkg.sv
design/lsuk_cell.sv
design/lifo_stack_unique_keys.sv
sim/testbench.sv
